/* src/apq_pkg.sv */
// ----------------------------------------------------------------------------
// apq_pkg
// Shared constants, types and the colour distance function of the adaptive
// palette quantizer.
// ----------------------------------------------------------------------------
package apq_pkg;

  // Palette depth, entry 0 included.
  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int COUNT_W         = $clog2(PALETTE_ENTRIES + 1);
  localparam int COLOUR_W        = 15;
  localparam int CH_W            = 5;
  // Sum of three squared 5-bit differences stays below 2^12.
  localparam int DIST_W          = 12;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [CH_W-1:0]     chan_t;

  // Absolute difference of two 5-bit channels.
  function automatic chan_t chan_diff(input chan_t a, input chan_t b);
    chan_t d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

  // Squared RGB distance on 5-bit channels. Shifting every channel up by
  // three bits scales the sum by 64, which keeps the ordering unchanged.
  function automatic dist_t colour_dist(input colour_t a, input colour_t b);
    chan_t dr;
    chan_t dg;
    chan_t db;
    dr = chan_diff(a[4:0], b[4:0]);
    dg = chan_diff(a[9:5], b[9:5]);
    db = chan_diff(a[14:10], b[14:10]);
    return (dist_t'(dr) * dist_t'(dr)) + (dist_t'(dg) * dist_t'(dg)) +
           (dist_t'(db) * dist_t'(db));
  endfunction

endpackage

/* src/apq_ram.sv */
// ----------------------------------------------------------------------------
// apq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/adaptive_palette_quantizer.sv */
// ----------------------------------------------------------------------------
// adaptive_palette_quantizer
// Maps RGBA8888 pixels to 8-bit indexes of an RGB555 palette that is built
// as the image streams through.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. A transparent pixel (alpha below 128), or
// any pixel while only the transparent entry is in use, goes from acceptance
// straight to the final state, which loads its result into the output
// register. Any other pixel is first scanned against the palette: the
// palette RAM has a single read port, and every entry from 1 to count-1 is
// read and compared once, where count is the number of palette entries in
// use. A finished result waits while the output register still holds an
// untaken one; a new pixel is taken as soon as the previous result sits in
// the output register, even if that result has not been taken yet. Entry 0
// is the transparent entry and is never read from the palette RAM; its
// result colour is zero, and the RAM needs no clearing after reset or at an
// image start.
module adaptive_palette_quantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pixel_rgba[31:0]
  input  logic        s_axis_tuser,  // first_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_index[7:0], entry_added[8], entry_colour[23:9], entries_used[32:24],
  // zero fill[39:33]
  output logic [39:0] m_axis_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state;
  apq_pkg::count_t  count;
  apq_pkg::colour_t colour;
  logic             transp;
  apq_pkg::count_t  issue_ptr;
  apq_pkg::addr_t   data_idx;
  logic             data_vld;
  apq_pkg::dist_t   best_d;
  apq_pkg::addr_t   best_idx;
  apq_pkg::colour_t best_colour;

  logic             out_valid;
  logic [7:0]       out_index;
  logic             out_added;
  apq_pkg::colour_t out_colour;
  logic [8:0]       out_used;

  logic             accept;
  logic             opaque;
  apq_pkg::colour_t in_colour;
  apq_pkg::count_t  count_in;
  logic             out_free;
  logic             match;
  logic             add;
  logic             last;
  apq_pkg::dist_t   scan_dist;

  logic             rd_en;
  apq_pkg::addr_t   rd_addr;
  apq_pkg::colour_t rd_data;
  logic             wr_en;

  // Input decode
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign opaque        = s_axis_tdata[31];
  assign in_colour     = {s_axis_tdata[23:19], s_axis_tdata[15:11], s_axis_tdata[7:3]};
  assign count_in      = s_axis_tuser ? apq_pkg::count_t'(1) : count;

  // Scan compare on the registered RAM data
  assign scan_dist = apq_pkg::colour_dist(colour, rd_data);
  assign last      = data_vld && (apq_pkg::count_t'(data_idx) == count - apq_pkg::count_t'(1));

  // Final decision
  assign out_free = !out_valid || m_axis_tready;
  assign match    = (best_d == '0);
  assign add      = !transp && !match &&
                    (count < apq_pkg::count_t'(apq_pkg::PALETTE_ENTRIES));
  assign wr_en    = (state == S_FIN) && out_free && add;

  // Read port: first entry on acceptance, then one entry per cycle
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = apq_pkg::addr_t'(1);
    if (accept && opaque && (count_in > apq_pkg::count_t'(1))) begin
      rd_en = 1'b1;
    end else if ((state == S_SCAN) && (issue_ptr < count)) begin
      rd_en   = 1'b1;
      rd_addr = issue_ptr[apq_pkg::ADDR_W-1:0];
    end
  end

  // Palette store; a write in S_FIN always lands before the next scan reads
  apq_ram #(
    .WIDTH (apq_pkg::COLOUR_W),
    .DEPTH (apq_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[apq_pkg::ADDR_W-1:0]),
    .wr_data (colour),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, scan datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= apq_pkg::count_t'(1);
      data_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count  <= count_in;
            colour <= in_colour;
            transp <= !opaque;
            best_d <= '1;
            if (opaque && (count_in > apq_pkg::count_t'(1))) begin
              state     <= S_SCAN;
              data_vld  <= 1'b1;
              data_idx  <= apq_pkg::addr_t'(1);
              issue_ptr <= apq_pkg::count_t'(2);
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          // keep the first entry with the least distance
          if (data_vld && (scan_dist < best_d)) begin
            best_d      <= scan_dist;
            best_idx    <= data_idx;
            best_colour <= rd_data;
          end
          if (issue_ptr < count) begin
            data_vld  <= 1'b1;
            data_idx  <= issue_ptr[apq_pkg::ADDR_W-1:0];
            issue_ptr <= issue_ptr + apq_pkg::count_t'(1);
          end else begin
            data_vld <= 1'b0;
          end
          if (last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (out_free) begin
            state <= S_IDLE;
            if (transp) begin
              out_index  <= 8'd0;
              out_added  <= 1'b0;
              out_colour <= '0;
              out_used   <= 9'(count);
            end else if (add) begin
              out_index  <= 8'(count[apq_pkg::ADDR_W-1:0]);
              out_added  <= 1'b1;
              out_colour <= colour;
              out_used   <= 9'(count) + 9'd1;
              count      <= count + apq_pkg::count_t'(1);
            end else begin
              out_index  <= 8'(best_idx);
              out_added  <= 1'b0;
              out_colour <= best_colour;
              out_used   <= 9'(count);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_used, out_colour, out_added, out_index};

  // Palette count stays within its legal range
  assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= apq_pkg::count_t'(apq_pkg::PALETTE_ENTRIES)))
    else $error("palette count out of range");

  // A new entry always lands at the end of the palette
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_added) |-> (out_used == 9'(out_index) + 9'd1))
    else $error("added entry not at end of palette");

  // Index 0 is only ever the transparent entry
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_index == 8'd0)) |-> ((out_colour == '0) && !out_added))
    else $error("transparent result carries colour or add flag");

  // The scan never reads past the entries in use
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && data_vld) |-> (apq_pkg::count_t'(data_idx) < count))
    else $error("scan index beyond palette count");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adaptive palette quantizer: drives RGBA pixels
// in bursts, predicts every palette index, addition and count in a scoreboard
// and compares each output transaction field by field.
// ----------------------------------------------------------------------------

class quant_scoreboard;

  typedef struct packed {
    logic [7:0]       index;
    logic             added;
    apq_pkg::colour_t colour;
    logic [8:0]       used;
  } quant_result_t;

  localparam int ALPHA_OPAQUE = 128;

  apq_pkg::colour_t palette [apq_pkg::PALETTE_ENTRIES];
  int               entries;
  quant_result_t    expected_q [$];
  int               errors;

  function new();
    palette[0] = '0;
    entries    = 1;
    errors     = 0;
  endfunction

  // Squared distance with every channel scaled back up to 8 bits.
  function int sq_dist(input apq_pkg::colour_t a, input apq_pkg::colour_t b);
    int dr;
    int dg;
    int db;
    dr = (int'(a[4:0]) - int'(b[4:0])) * 8;
    dg = (int'(a[9:5]) - int'(b[9:5])) * 8;
    db = (int'(a[14:10]) - int'(b[14:10])) * 8;
    return dr * dr + dg * dg + db * db;
  endfunction

  // Update the palette for one accepted pixel and queue its expected result.
  function void note_pixel(input bit first, input logic [31:0] rgba);
    apq_pkg::colour_t c;
    int               idx;
    int               best_d;
    int               d;
    bit               added;
    bit               found;
    quant_result_t    res;
    if (first) begin
      palette[0] = '0;
      entries    = 1;
    end
    idx   = 0;
    added = 1'b0;
    found = 1'b0;
    if (int'(rgba[31:24]) >= ALPHA_OPAQUE) begin
      c = {rgba[23:19], rgba[15:11], rgba[7:3]};
      // First exact match wins
      for (int i = 1; i < entries; i++) begin
        if (!found && palette[i] == c) begin
          idx   = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (entries < apq_pkg::PALETTE_ENTRIES) begin
          idx          = entries;
          palette[idx] = c;
          entries++;
          added = 1'b1;
        end else begin
          // Nearest colour, lowest index on a tie
          idx    = 1;
          best_d = 32'h7FFF_FFFF;
          for (int i = 1; i < apq_pkg::PALETTE_ENTRIES; i++) begin
            d = sq_dist(c, palette[i]);
            if (d < best_d) begin
              best_d = d;
              idx    = i;
            end
          end
        end
      end
    end
    res.index  = idx[7:0];
    res.added  = added;
    res.colour = palette[idx];
    res.used   = entries[8:0];
    expected_q.push_back(res);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void compare_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t ERROR %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare one output transaction with the oldest expectation.
  function void check_result(input logic [39:0] beat);
    quant_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t ERROR result with no pixel pending, actual 0x%0h", $time, beat);
      errors++;
    end else begin
      want = expected_q.pop_front();
      compare_field("pixel_index", want.index, beat[7:0]);
      compare_field("entry_added", want.added, beat[8]);
      compare_field("entry_colour", want.colour, beat[23:9]);
      compare_field("entries_used", want.used, beat[32:24]);
      compare_field("zero_fill", 0, beat[39:33]);
    end
  endfunction

endclass

module testbench;

  localparam int ITEM_TARGET  = 1650;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int FILL_COLOURS = apq_pkg::PALETTE_ENTRIES - 1;
  // Typical number of pixels in one fill image
  localparam int FILL_ITEMS   = 350;

  typedef enum int {RX_STREAM, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  quant_scoreboard sb;
  int              items_sent = 0;
  int              burst_left = 0;
  int              cycle_count = 0;
  rx_mode_t        rx_mode = RX_STREAM;
  int              rx_mode_left = 0;
  int              rx_hold = 0;

  adaptive_palette_quantizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Build an RGBA pixel for a palette colour with random low channel bits.
  function automatic logic [31:0] rgba_of(input apq_pkg::colour_t c,
                                          input logic [7:0] alpha);
    return {alpha,
            c[14:10], 3'($urandom_range(0, 7)),
            c[9:5],   3'($urandom_range(0, 7)),
            c[4:0],   3'($urandom_range(0, 7))};
  endfunction

  function automatic logic [7:0] opaque_alpha();
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] clear_alpha();
    return 8'($urandom_range(0, 127));
  endfunction

  // Send one pixel; open a new burst after a random gap when the last one ends.
  task automatic send_pixel(input bit first, input logic [31:0] rgba);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= rgba;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pixel(first, rgba);
    items_sent++;
  endtask

  // Fill the palette with distinct colours, then probe the full palette.
  task automatic send_fill_image();
    apq_pkg::colour_t fill_col [FILL_COLOURS];
    int               stride;
    int               base;
    int               queries;
    int               pick;
    apq_pkg::colour_t c;
    stride = ($urandom_range(0, 1) == 1) ? 1 : $urandom_range(0, 16383) * 2 + 1;
    base   = $urandom_range(0, 32767);
    for (int i = 0; i < FILL_COLOURS; i++) begin
      c = 15'(base + (i + 1) * stride);
      fill_col[i] = c;
      // Mix in transparent pixels and repeats while the palette grows
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1)
          send_pixel(1'b0, rgba_of(15'($urandom), clear_alpha()));
        else
          send_pixel(1'b0, rgba_of(fill_col[$urandom_range(0, i - 1)], opaque_alpha()));
      end
      send_pixel(i == 0, rgba_of(c, opaque_alpha()));
    end
    queries = $urandom_range(30, 70);
    for (int q = 0; q < queries; q++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        send_pixel(1'b0, {opaque_alpha(), 24'($urandom)});
      else if (pick < 17)
        send_pixel(1'b0, rgba_of(fill_col[$urandom_range(0, FILL_COLOURS - 1)],
                                 opaque_alpha()));
      else
        send_pixel(1'b0, $urandom & 32'h7FFF_FFFF);
    end
  endtask

  // Short image drawn from a small colour pool, with noise and stray clears.
  task automatic send_small_image();
    apq_pkg::colour_t pool [40];
    int               pool_size;
    int               pixels;
    int               pick;
    bit               first;
    pool_size = $urandom_range(1, 40);
    pixels    = $urandom_range(5, 60);
    for (int i = 0; i < pool_size; i++) pool[i] = 15'($urandom);
    for (int p = 0; p < pixels; p++) begin
      first = (p == 0) && ($urandom_range(0, 5) != 0);
      pick  = $urandom_range(0, 99);
      if (pick < 80)
        send_pixel(first, rgba_of(pool[$urandom_range(0, pool_size - 1)], opaque_alpha()));
      else if (pick < 90)
        send_pixel(first, {clear_alpha(), 24'($urandom)});
      else if (pick < 97)
        send_pixel(first, $urandom);
      else
        send_pixel(1'b1, $urandom);
    end
  endtask

  // Check output transactions and drive the stall pattern of the receiver.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_tready) sb.check_result(m_axis_tdata);
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(64, 600);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_STREAM: begin
          m_tready <= 1'b1;
        end
        RX_RANDOM: begin
          m_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (rx_hold == 0) begin
            m_tready <= ~m_tready;
            rx_hold = m_tready ? $urandom_range(1, 40) : $urandom_range(1, 6);
          end else begin
            rx_hold--;
          end
        end
      endcase
    end
  end

  // Abort a run that exceeds the cycle limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: palette carries on from reset without a clear
    send_pixel(1'b0, 32'h0000_0000);
    send_pixel(1'b0, 32'hFF00_0000);
    send_pixel(1'b0, 32'hFFFF_FFFF);
    send_pixel(1'b0, 32'h80FF_FFFF);
    send_pixel(1'b0, 32'h7FFF_FFFF);
    // Low channel bits are dropped before matching
    send_pixel(1'b0, 32'hFF07_0707);
    send_pixel(1'b0, 32'h80F8_F8F8);
    // Image start on a transparent pixel, then on an opaque one
    send_pixel(1'b1, 32'h7F12_3456);
    send_pixel(1'b0, 32'hFF00_00FF);
    send_pixel(1'b0, 32'hFF00_FF00);
    send_pixel(1'b0, 32'hFFFF_0000);
    send_pixel(1'b0, 32'hFF00_00FF);
    send_pixel(1'b1, 32'hFFFF_FFFF);
    send_pixel(1'b0, 32'h00FF_FFFF);
    send_pixel(1'b1, 32'h8000_0000);
    send_pixel(1'b0, 32'hFF84_2108);

    // Random images: full palettes with nearest searches, and short images
    send_fill_image();
    while (items_sent < ITEM_TARGET) begin
      if ((items_sent + FILL_ITEMS < ITEM_TARGET) && ($urandom_range(0, 6) == 0))
        send_fill_image();
      else
        send_small_image();
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
src/apq_pkg.sv
src/apq_ram.sv
src/adaptive_palette_quantizer.sv
sim/testbench.sv
